### hdl/ics_pkg.sv
// shared types and constants for the internet checksum stream block
// no dependencies
`default_nettype none

package ics_pkg;

  // item kind carried on the input tuser bit
  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_MARKER = 1'b1;

  localparam int SUM_W  = 16;
  localparam int BYTE_W = 8;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;
    logic              packet_last;
  } item_t;

  // one's complement add with end-around carry
  function automatic logic [SUM_W-1:0] ones_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
  endfunction

endpackage

`default_nettype wire

### hdl/ics_in_reg.sv
// input register stage: captures one beat per cycle from the slave side while the stage is free
// depends on ics_pkg
`default_nettype none

module ics_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ics_pkg::item_t in_item,
  output logic               item_valid,
  output ics_pkg::item_t     item,
  input  wire logic          advance
);

  // stage is free when empty or when its beat moves on this cycle
  assign in_ready = !item_valid || advance;

  // stage valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

### hdl/ics_accum.sv
// running one's complement sum, odd byte pairing and result register
// depends on ics_pkg
`default_nettype none

module ics_accum (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  input  wire ics_pkg::item_t item,
  output logic                advance,
  output logic                res_valid,
  input  wire logic           res_ready,
  output logic [ics_pkg::SUM_W-1:0] res_checksum
);

  logic [ics_pkg::SUM_W-1:0]  running_sum;
  logic [ics_pkg::BYTE_W-1:0] pending_byte;
  logic                       pending_valid;

  logic [ics_pkg::SUM_W-1:0]  addend;
  logic                       do_add;
  logic [ics_pkg::SUM_W-1:0]  running_sum_next;
  logic [ics_pkg::BYTE_W-1:0] pending_byte_next;
  logic                       pending_valid_next;
  logic                       res_free;

  // result slot is free when empty or being taken
  assign res_free = !res_valid || res_ready;
  assign advance  = item_valid && (!item.packet_last || res_free);

  // pick the single word this beat adds, if any
  always_comb begin
    addend             = '0;
    do_add             = 1'b0;
    pending_byte_next  = pending_byte;
    pending_valid_next = pending_valid;
    if (item.opcode == ics_pkg::OP_DATA) begin
      if (pending_valid) begin
        addend             = {item.data_byte, pending_byte};
        do_add             = 1'b1;
        pending_valid_next = 1'b0;
      end else if (item.packet_last) begin
        // odd byte at end of packet goes in alone
        addend = {{ics_pkg::BYTE_W{1'b0}}, item.data_byte};
        do_add = 1'b1;
      end else begin
        pending_byte_next  = item.data_byte;
        pending_valid_next = 1'b1;
      end
    end else begin
      // marker flushes a held odd byte
      if (pending_valid) begin
        addend             = {{ics_pkg::BYTE_W{1'b0}}, pending_byte};
        do_add             = 1'b1;
        pending_valid_next = 1'b0;
      end
    end
    running_sum_next = do_add ? ics_pkg::ones_add(running_sum, addend) : running_sum;
  end

  // sum state, cleared after each packet
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      pending_byte  <= '0;
      pending_valid <= 1'b0;
    end else if (advance) begin
      if (item.packet_last) begin
        running_sum   <= '0;
        pending_byte  <= '0;
        pending_valid <= 1'b0;
      end else begin
        running_sum   <= running_sum_next;
        pending_byte  <= pending_byte_next;
        pending_valid <= pending_valid_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && item.packet_last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.packet_last) begin
      res_checksum <= ~running_sum_next;
    end
  end

endmodule

`default_nettype wire

### hdl/internet_checksum_stream.sv
// top level: one's complement internet checksum over a gathered byte stream
// depends on ics_pkg, ics_in_reg, ics_accum
// a packet end waits in the input register while a checksum is still untaken
// throughput: else one beat per cycle, set by the single 16-bit end-around add
// the result register lets new beats enter while a checksum waits to be taken
// reset: synchronous, clears the sum, held byte and all three valid flags
`default_nettype none

module internet_checksum_stream (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] opcode
  input  wire logic        s_tlast,   // packet_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [15:0] checksum
);

  ics_pkg::item_t in_item;
  ics_pkg::item_t item;
  logic           item_valid;
  logic           advance;

  // pack the slave-side beat
  always_comb begin
    in_item.opcode      = s_tuser;
    in_item.data_byte   = s_tdata;
    in_item.packet_last = s_tlast;
  end

  ics_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance)
  );

  ics_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .advance      (advance),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .res_checksum (m_tdata)
  );

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking bench for internet_checksum_stream: directed and random packets
// predicts each checksum from its own running sum and compares every result beat
// depends on ics_pkg and the internet_checksum_stream rtl
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_LEN    = 300;
  localparam int TAIL_CYCLES = 8;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
  logic        s_tuser  = ics_pkg::OP_DATA; // [0] opcode
  logic        s_tlast  = 1'b0;   // packet_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [15:0] checksum

  // predictor state for the packet in flight
  logic [15:0] sum_acc    = 16'h0000;
  logic [7:0]  held_byte  = 8'h00;
  logic        held_valid = 1'b0;

  logic [15:0] checksum_q[$];

  int  err_count      = 0;
  int  items_sent     = 0;
  int  checksums_seen = 0;
  int  hold_reqs      = 0;
  bit  src_idle_en    = 1'b1;
  bit  sink_idle_en   = 1'b1;

  internet_checksum_stream u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  // 16-bit add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 16'hFFFF) s = s - 16'hFFFF;
    return s[15:0];
  endfunction

  // an unpaired byte goes in alone as the low half
  function automatic void flush_held();
    if (held_valid) begin
      sum_acc    = fold_add(sum_acc, {8'h00, held_byte});
      held_valid = 1'b0;
      held_byte  = 8'h00;
    end
  endfunction

  // advance the running sum by one accepted beat, queue a checksum at packet end
  function automatic void predict_checksum(input logic op, input logic [7:0] b,
                                           input logic last);
    if (op == ics_pkg::OP_DATA) begin
      if (held_valid) begin
        sum_acc    = fold_add(sum_acc, {b, held_byte});
        held_valid = 1'b0;
        held_byte  = 8'h00;
      end else begin
        held_byte  = b;
        held_valid = 1'b1;
      end
    end else begin
      flush_held();
    end
    if (last) begin
      flush_held();
      checksum_q.push_back(~sum_acc);
      sum_acc = 16'h0000;
    end
  endfunction

  // offer one beat after a random gap and wait for the handshake
  task automatic send_beat(input logic op, input logic [7:0] b, input logic last);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= op;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_checksum(op, b, last);
    items_sent++;
  endtask

  // sender stops and waits until every checksum has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (checksum_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // one packet of random bytes with markers mixed in
  task automatic send_packet(input int len, input int marker_pct);
    logic       op;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      op = ($urandom_range(0, 99) < marker_pct) ? ics_pkg::OP_MARKER : ics_pkg::OP_DATA;
      b  = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      send_beat(op, b, i == len - 1);
    end
  endtask

  task automatic test_directed();
    // empty packet
    send_beat(ics_pkg::OP_MARKER, 8'hA5, 1'b1);
    // lone byte at both extremes, flushed by end of packet
    send_beat(ics_pkg::OP_DATA, 8'h00, 1'b1);
    send_beat(ics_pkg::OP_DATA, 8'hFF, 1'b1);
    // all ones words force the end-around carry
    repeat (3) send_beat(ics_pkg::OP_DATA, 8'hFF, 1'b0);
    send_beat(ics_pkg::OP_DATA, 8'hFF, 1'b1);
    // marker flushes a held byte, pairing restarts after it
    send_beat(ics_pkg::OP_DATA, 8'h12, 1'b0);
    send_beat(ics_pkg::OP_MARKER, 8'h5A, 1'b0);
    send_beat(ics_pkg::OP_DATA, 8'h34, 1'b0);
    send_beat(ics_pkg::OP_DATA, 8'h56, 1'b1);
    // marker with nothing held, then ending marker with nothing held
    send_beat(ics_pkg::OP_MARKER, 8'hFF, 1'b0);
    send_beat(ics_pkg::OP_DATA, 8'hAB, 1'b0);
    send_beat(ics_pkg::OP_DATA, 8'hCD, 1'b0);
    send_beat(ics_pkg::OP_MARKER, 8'h00, 1'b1);
    // ending marker with a held byte
    send_beat(ics_pkg::OP_DATA, 8'h01, 1'b0);
    send_beat(ics_pkg::OP_DATA, 8'h02, 1'b0);
    send_beat(ics_pkg::OP_DATA, 8'h03, 1'b0);
    send_beat(ics_pkg::OP_MARKER, 8'hC3, 1'b1);
    // odd length packet ending on a data beat
    send_beat(ics_pkg::OP_DATA, 8'h80, 1'b0);
    send_beat(ics_pkg::OP_DATA, 8'h7F, 1'b0);
    send_beat(ics_pkg::OP_DATA, 8'h01, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_packets(input int n_items);
    int stop_at;
    int len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      // some packets run back to back with no idling on either side
      src_idle_en  = ($urandom_range(0, 4) != 0);
      sink_idle_en = ($urandom_range(0, 4) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      send_packet(len, 15);
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    wait_drained();
  endtask

  // receiver stalls long while short packets keep coming, so the input backs up
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_reqs <= hold_reqs + 1;
    repeat (30) send_packet($urandom_range(1, 3), 20);
    src_idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_full_rate();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (20) send_packet($urandom_range(1, 8), 10);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    wait_drained();
  endtask

  // result side: check each beat, then pick the next ready pattern
  initial begin : result_sink
    int          wait_left;
    int          hold_left;
    int          hold_taken;
    logic [15:0] want;
    wait_left  = 0;
    hold_left  = 0;
    hold_taken = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        checksums_seen++;
        if (checksum_q.size() == 0) begin
          report_mismatch($sformatf("checksum %h with none expected", m_tdata));
        end else begin
          want = checksum_q.pop_front();
          if (m_tdata !== want)
            report_mismatch($sformatf("checksum %h, expected %h", m_tdata, want));
        end
        wait_left = sink_idle_en ? $urandom_range(0, 13) : 0;
      end
      if (hold_reqs != hold_taken) begin
        hold_taken = hold_reqs;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("timeout: no beat for %0d cycles, %0d checksums outstanding",
             STALL_LIMIT, checksum_q.size());
    $display("testbench failed");
    $finish;
  end

  initial begin : main
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_packets(380);
    test_backpressure();
    test_full_rate();
    if (checksum_q.size() != 0)
      report_mismatch($sformatf("%0d checksums never arrived", checksum_q.size()));
    $display("covered %0d input beats and %0d checksums: empty, odd, carry, marker cases,",
             items_sent, checksums_seen);
    $display("random gaps on both sides, a long output stall and full rate streaming");
    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ics_pkg.sv
hdl/ics_in_reg.sv
hdl/ics_accum.sv
hdl/internet_checksum_stream.sv
bench/testbench.sv
